@@ hw/rtl/kpr_pkg.sv @@
// ----------------------------------------------------------------------------
// kpr_pkg: shared constants for the k-space phase ramp shifter
// Register indexes, quadrant codes, gain and arctangent constants.
// ----------------------------------------------------------------------------
package kpr_pkg;

    localparam int COEF_WIDTH   = 32;
    localparam int TRAJ_WIDTH   = 16;
    localparam int PHASE_WIDTH  = 32;
    localparam int GUARD_BITS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CFG_IDX_WIDTH = 2;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_SECOND = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_FIRST  = 2'd1;

    // Quadrant codes: rotation by code * 90 degrees
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    // Inverse CORDIC gain, Q1.30, held as a positive 31-bit signed value
    localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;

    // Arctangent of 2^-i, 2^32 per turn
    localparam logic [PHASE_WIDTH-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

@@ hw/rtl/kpr_front.sv @@
// ----------------------------------------------------------------------------
// kpr_front: phase, quadrant and gain stages
// Three registered stages: coordinate products, phase word with quadrant
// rotation, and inverse-gain scaling of the rotated sample.
// ----------------------------------------------------------------------------
module kpr_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DATA_WIDTH   = 34
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [31:0]             coef_first,
    input  logic signed [31:0]             coef_second,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_re,
    input  logic signed [SAMPLE_WIDTH-1:0] in_im,
    input  logic signed [15:0]             in_traj_first,
    input  logic signed [15:0]             in_traj_second,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [DATA_WIDTH-1:0]   out_x,
    output logic signed [DATA_WIDTH-1:0]   out_y,
    output logic signed [31:0]             out_z
);
    import kpr_pkg::*;

    localparam int PROD_WIDTH = SAMPLE_WIDTH + 32;

    // Stage 1: low phase bits of each product
    logic                           s1_valid_reg;
    logic [30:0]                    s1_p1_reg;
    logic [30:0]                    s1_p2_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_im_reg;
    logic signed [47:0]             p1_full;
    logic signed [47:0]             p2_full;
    logic                           s1_ready;

    // Stage 2: quadrant-rotated sample and residual angle
    logic                           s2_valid_reg;
    logic signed [SAMPLE_WIDTH:0]   s2_x_reg;
    logic signed [SAMPLE_WIDTH:0]   s2_y_reg;
    logic signed [31:0]             s2_z_reg;
    logic signed [SAMPLE_WIDTH:0]   x_next;
    logic signed [SAMPLE_WIDTH:0]   y_next;
    logic [PHASE_WIDTH-1:0]         phase;
    logic [PHASE_WIDTH-1:0]         phase_bias;
    logic [1:0]                     quad;
    logic [PHASE_WIDTH-1:0]         resid;
    logic [30:0]                    phase_sum;
    logic signed [SAMPLE_WIDTH:0]   re_ext;
    logic signed [SAMPLE_WIDTH:0]   im_ext;
    logic                           s2_ready;

    // Stage 3: gain-scaled sample
    logic                           s3_valid_reg;
    logic signed [DATA_WIDTH-1:0]   s3_x_reg;
    logic signed [DATA_WIDTH-1:0]   s3_y_reg;
    logic signed [31:0]             s3_z_reg;
    logic signed [PROD_WIDTH-1:0]   gx;
    logic signed [PROD_WIDTH-1:0]   gy;
    logic signed [PROD_WIDTH-1:0]   round_c;
    logic                           s3_ready;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign p1_full = coef_first * in_traj_first;
    assign p2_full = coef_second * in_traj_second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_p1_reg <= p1_full[30:0];
            s1_p2_reg <= p2_full[30:0];
            s1_re_reg <= in_re;
            s1_im_reg <= in_im;
        end
    end

    // Fraction bits of the sum form the phase word; bit 0 is always clear
    assign phase_sum  = s1_p1_reg + s1_p2_reg;
    assign phase      = {phase_sum, 1'b0};
    assign phase_bias = phase + 32'h2000_0000;
    assign quad       = phase_bias[31:30];
    assign resid      = phase - {quad, 30'd0};
    assign re_ext     = {s1_re_reg[SAMPLE_WIDTH-1], s1_re_reg};
    assign im_ext     = {s1_im_reg[SAMPLE_WIDTH-1], s1_im_reg};

    always_comb
    begin
        unique case (quad)
            QUAD_90:
            begin
                x_next = -im_ext;
                y_next = re_ext;
            end
            QUAD_180:
            begin
                x_next = -re_ext;
                y_next = -im_ext;
            end
            QUAD_270:
            begin
                x_next = im_ext;
                y_next = -re_ext;
            end
            default:
            begin
                x_next = re_ext;
                y_next = im_ext;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_x_reg <= x_next;
            s2_y_reg <= y_next;
            s2_z_reg <= $signed(resid);
        end
    end

    // Scale by the inverse gain and round half up to GUARD_BITS fraction bits
    assign round_c = PROD_WIDTH'(1) <<< (29 - GUARD_BITS);
    assign gx = PROD_WIDTH'(s2_x_reg) * PROD_WIDTH'(INV_GAIN_Q30) + round_c;
    assign gy = PROD_WIDTH'(s2_y_reg) * PROD_WIDTH'(INV_GAIN_Q30) + round_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_x_reg <= gx[30-GUARD_BITS +: DATA_WIDTH];
            s3_y_reg <= gy[30-GUARD_BITS +: DATA_WIDTH];
            s3_z_reg <= s2_z_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_x     = s3_x_reg;
    assign out_y     = s3_y_reg;
    assign out_z     = s3_z_reg;

endmodule

@@ hw/rtl/kpr_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// kpr_cordic_cell: one CORDIC rotation stage
// Rotates by the arctangent of 2^-SHIFT toward a zero residual angle and
// registers the result for the next cell.
// ----------------------------------------------------------------------------
module kpr_cordic_cell #(
    parameter int DATA_WIDTH = 34,
    parameter int SHIFT      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] in_x,
    input  logic signed [DATA_WIDTH-1:0] in_y,
    input  logic signed [31:0]           in_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_x,
    output logic signed [DATA_WIDTH-1:0] out_y,
    output logic signed [31:0]           out_z
);
    import kpr_pkg::*;

    localparam logic signed [31:0] ANGLE = $signed(ATAN_TURNS[SHIFT]);

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] y_reg;
    logic signed [31:0]           z_reg;
    logic signed [DATA_WIDTH-1:0] dx;
    logic signed [DATA_WIDTH-1:0] dy;
    logic signed [DATA_WIDTH-1:0] x_next;
    logic signed [DATA_WIDTH-1:0] y_next;
    logic signed [31:0]           z_next;

    assign in_ready = !valid_reg || out_ready;
    assign dx = in_y >>> SHIFT;
    assign dy = in_x >>> SHIFT;

    always_comb
    begin
        if (!in_z[31])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ANGLE;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

@@ hw/rtl/kpr_round_sat.sv @@
// ----------------------------------------------------------------------------
// kpr_round_sat: output rounding and saturation
// Drops the guard bits with round half up, clamps to the sample range and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module kpr_round_sat #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DATA_WIDTH   = 34
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [DATA_WIDTH-1:0]   in_x,
    input  logic signed [DATA_WIDTH-1:0]   in_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_re,
    output logic signed [SAMPLE_WIDTH-1:0] out_im
);
    import kpr_pkg::*;

    localparam int RND_WIDTH = DATA_WIDTH - GUARD_BITS;

    localparam logic signed [RND_WIDTH-1:0] SAT_HI =
        {{(RND_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [RND_WIDTH-1:0] SAT_LO =
        {{(RND_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] re_reg;
    logic signed [SAMPLE_WIDTH-1:0] im_reg;
    logic signed [DATA_WIDTH-1:0]   x_rnd;
    logic signed [DATA_WIDTH-1:0]   y_rnd;
    logic signed [RND_WIDTH-1:0]    x_short;
    logic signed [RND_WIDTH-1:0]    y_short;
    logic signed [SAMPLE_WIDTH-1:0] re_next;
    logic signed [SAMPLE_WIDTH-1:0] im_next;

    assign in_ready = !valid_reg || out_ready;

    assign x_rnd   = in_x + (DATA_WIDTH'(1) <<< (GUARD_BITS - 1));
    assign y_rnd   = in_y + (DATA_WIDTH'(1) <<< (GUARD_BITS - 1));
    assign x_short = x_rnd[DATA_WIDTH-1:GUARD_BITS];
    assign y_short = y_rnd[DATA_WIDTH-1:GUARD_BITS];

    always_comb
    begin
        if (x_short > SAT_HI)
            re_next = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (x_short < SAT_LO)
            re_next = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            re_next = x_short[SAMPLE_WIDTH-1:0];

        if (y_short > SAT_HI)
            im_next = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (y_short < SAT_LO)
            im_next = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            im_next = y_short[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;

endmodule

@@ hw/rtl/kspace_phase_ramp_shift.sv @@
// ----------------------------------------------------------------------------
// kspace_phase_ramp_shift: linear phase ramp for k-space field-of-view shift
// Rotates each complex sample by coef_first * traj_first +
// coef_second * traj_second turns with a pipelined CORDIC chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one sample with its two trajectory coordinates
//   per transfer. Output stream (m_axis_*): the rotated, saturated sample.
//   Configuration channel (cfg_*): index 0 writes coef_second_axis, index 1
//   writes coef_first_axis (signed Q1.31 turns per unit coordinate); other
//   indexes are dropped. cfg_ready is always high. Write only while idle.
//   Pipeline: three front stages, one per CORDIC cell, one rounding stage,
//   with ROTATION_STAGES capped at the 24 cells of the arctangent table.
//   Throughput: one sample per cycle while m_axis_tready stays high; every
//   stage is a register with its own valid bit.
//   Reset clears all valid bits and both coefficients to zero.
//   Stall: when m_axis_tready is low the output holds; earlier stages keep
//   filling until every stage is occupied, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module kspace_phase_ramp_shift #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int ROTATION_STAGES = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // sample_re, sample_im, traj_first, traj_second, zero fill
    input  logic [((2*SAMPLE_WIDTH+32+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // shifted_re, shifted_im, zero fill
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [kpr_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
    input  logic [kpr_pkg::COEF_WIDTH-1:0]           cfg_data
);
    import kpr_pkg::*;

    localparam int DATA_WIDTH = SAMPLE_WIDTH + GUARD_BITS + 2;
    localparam int NUM_CELLS  =
        (ROTATION_STAGES < ATAN_ENTRIES) ? ROTATION_STAGES : ATAN_ENTRIES;
    localparam int OUT_BITS   = ((2*SAMPLE_WIDTH+7)/8)*8;

    logic signed [COEF_WIDTH-1:0]   coef_second_reg;
    logic signed [COEF_WIDTH-1:0]   coef_first_reg;

    logic                           link_valid [NUM_CELLS+1];
    logic                           link_ready [NUM_CELLS+1];
    logic signed [DATA_WIDTH-1:0]   link_x     [NUM_CELLS+1];
    logic signed [DATA_WIDTH-1:0]   link_y     [NUM_CELLS+1];
    logic signed [31:0]             link_z     [NUM_CELLS+1];

    logic signed [SAMPLE_WIDTH-1:0] shifted_re;
    logic signed [SAMPLE_WIDTH-1:0] shifted_im;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_second_reg <= '0;
            coef_first_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COEF_SECOND: coef_second_reg <= cfg_data;
                REG_COEF_FIRST:  coef_first_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    kpr_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .coef_first     (coef_first_reg),
        .coef_second    (coef_second_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_re          (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .in_im          (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .in_traj_first  (s_axis_tdata[2*SAMPLE_WIDTH+15:2*SAMPLE_WIDTH]),
        .in_traj_second (s_axis_tdata[2*SAMPLE_WIDTH+31:2*SAMPLE_WIDTH+16]),
        .out_valid      (link_valid[0]),
        .out_ready      (link_ready[0]),
        .out_x          (link_x[0]),
        .out_y          (link_y[0]),
        .out_z          (link_z[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        kpr_cordic_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .SHIFT      (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_x      (link_x[i]),
            .in_y      (link_y[i]),
            .in_z      (link_z[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_x     (link_x[i+1]),
            .out_y     (link_y[i+1]),
            .out_z     (link_z[i+1])
        );
    end

    kpr_round_sat #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_round_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[NUM_CELLS]),
        .in_ready  (link_ready[NUM_CELLS]),
        .in_x      (link_x[NUM_CELLS]),
        .in_y      (link_y[NUM_CELLS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_re    (shifted_re),
        .out_im    (shifted_im)
    );

    // residual angle is spent after the last cell
    logic z_unused;
    assign z_unused = ^link_z[NUM_CELLS];

    assign m_axis_tdata = OUT_BITS'({shifted_im, shifted_re});

endmodule
